@@ rtl/atb_pkg.sv @@
// Package for the adaptive threshold block: sizes, register indexes, helpers.
// No dependencies.
package atb_pkg;
	localparam int MaxWidth = 256;
	localparam int MaxHeight = 256;
	localparam int XW = $clog2(MaxWidth);
	localparam int YW = $clog2(MaxHeight);
	localparam int AW = XW + YW;
	localparam int SW = 24;
	localparam int CW = 9;
	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_INV = 2'd2;
	localparam logic [1:0] REG_THR = 2'd3;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EMIT = 1'b1;
	localparam logic [7:0] PIX_WHITE = 8'd255;
endpackage

@@ rtl/atb_div.sv @@
// Restoring divider, one quotient bit per cycle, 9-bit operands.
// Depends on atb_pkg.
module atb_div import atb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic          done,
	output logic [CW-1:0] quotient
);
	logic [CW-1:0] q_q, d_q;
	logic [CW:0]   r_q;
	logic [3:0]    n_q;
	logic          busy_q;
	logic [CW:0]   sh, df;
	assign sh = {r_q[CW-1:0], q_q[CW-1]};
	assign df = sh - {1'b0, d_q};
	assign quotient = q_q;
	assign done = busy_q && n_q == 4'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			n_q <= 4'(CW);
		end else if (busy_q) begin
			if (n_q == 4'd0) busy_q <= 1'b0;
			else n_q <= n_q - 4'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q && n_q != 4'd0) begin
			if (!df[CW]) begin
				r_q <= df;
				q_q <= {q_q[CW-2:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[CW-2:0], 1'b0};
			end
		end
	end
endmodule

@@ rtl/adaptive_threshold_binarizer.sv @@
// Adaptive threshold block: integral image build on load, windowed threshold on emit.
// Load: a read and a write-back per beat; the last load of a frame adds window division.
// Emit: five read steps through one port pair, count and two products, compare, output.
// Early emit gives an error beat; input stalls while busy or an output is pending.
// Reset clears control state and loads register defaults; stores are not cleared.
// Depends on atb_pkg, atb_div.
module adaptive_threshold_binarizer import atb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic         func,
	input  logic [7:0]   pixel_in,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [7:0]   pixel_out,
	output logic         last_of_frame,
	output logic         error,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [8:0]   cfg_data
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001, S_LRD = 8'b00000010, S_LWR = 8'b00000100,
		S_DIV = 8'b00001000, S_ERD = 8'b00010000, S_EMUL = 8'b00100000,
		S_ECMP = 8'b01000000, S_OUT = 8'b10000000
	} state_t;
	state_t st_q;
	logic [8:0] cw_q, ch_q, inv_q, thr_q;
	logic [8:0] w_q, h_q, win_q;
	logic [16:0] lc_q, ec_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [SW-1:0] rs_q;
	logic [7:0] pix_q, p_q;
	logic [2:0] k_q;
	logic [SW-1:0] mem [2**AW];
	logic [7:0] pmem [2**AW];
	logic [SW-1:0] rd_q;
	logic [7:0] prd_q;
	logic [AW-1:0] ra;
	logic [SW+1:0] acc_q;
	logic [33:0] bord_q, pc_q;
	logic [16:0] cnt_q;
	logic [8:0] hb, he, wb, we;
	logic [9:0] t;
	logic [8:0] hs, ws;
	logic div_start, div_done;
	logic [8:0] quo, mn;
	logic [16:0] total;
	logic full;
	logic [7:0] opix_q;
	logic olast_q, oerr_q;

	function automatic logic [8:0] clampd(input logic [8:0] v, input int mx);
		if (v == 9'd0) return 9'd1;
		if (int'(v) > mx) return 9'(mx);
		return v;
	endfunction

	assign total = 17'(w_q) * 17'(h_q);
	assign full = lc_q >= total;
	assign mn = w_q < h_q ? w_q : h_q;
	assign hs = 9'(y_q); assign ws = 9'(x_q);
	assign hb = hs >= win_q ? hs - win_q : 9'd0;
	assign he = (10'(hs) + 10'(win_q)) <= 10'(h_q) ? 9'(hs + win_q) : h_q;
	assign wb = ws >= win_q ? ws - win_q : 9'd0;
	assign we = (10'(ws) + 10'(win_q)) <= 10'(w_q) ? 9'(ws + win_q) : w_q;
	assign t = thr_q > 9'd256 ? 10'd256 : 10'(thr_q);
	assign div_start = st_q == S_LWR && lc_q + 17'd1 == total;

	atb_div u_div (.clk, .arst_n, .start(div_start), .dividend(mn),
		.divisor(inv_q == 9'd0 ? 9'd1 : inv_q), .done(div_done), .quotient(quo));

	// integral corner per step: 0 (he,we) 1 (hb,wb) 2 (hb,we) 3 (he,wb)
	logic [8:0] cr, cc;
	logic cz_q;
	always_comb begin
		case (k_q)
			3'd0: begin cr = he; cc = we; end
			3'd1: begin cr = hb; cc = wb; end
			3'd2: begin cr = hb; cc = we; end
			default: begin cr = he; cc = wb; end
		endcase
		if (st_q == S_LRD) ra = {YW'(y_q - YW'(1)), x_q};
		else ra = {YW'(cr - 9'd1), XW'(cc - 9'd1)};
	end

	assign in_stall = st_q != S_IDLE || out_valid;
	assign pixel_out = opix_q;
	assign last_of_frame = olast_q;
	assign error = oerr_q;

	always_ff @(posedge clk) begin
		rd_q <= mem[ra];
		prd_q <= pmem[{y_q, x_q}];
		if (st_q == S_LWR) begin
			mem[{y_q, x_q}] <= (y_q == '0 ? '0 : rd_q) + rs_q;
			pmem[{y_q, x_q}] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cw_q <= 9'd256; ch_q <= 9'd256; inv_q <= 9'd8; thr_q <= 9'd38;
			w_q <= 9'd256; h_q <= 9'd256; win_q <= '0;
			lc_q <= '0; ec_q <= '0; x_q <= '0; y_q <= '0; rs_q <= '0;
			out_valid <= 1'b0; k_q <= '0; cz_q <= 1'b0;
			pix_q <= '0; p_q <= '0; acc_q <= '0; bord_q <= '0; pc_q <= '0;
			cnt_q <= '0;
			opix_q <= '0; olast_q <= 1'b0; oerr_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH: cw_q <= cfg_data;
					REG_HEIGHT: ch_q <= cfg_data;
					REG_INV: inv_q <= cfg_data;
					REG_THR: thr_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && !in_stall) begin
					if (func == FUNC_LOAD) begin
						if (lc_q == '0 && ec_q == '0) begin
							w_q <= clampd(cw_q, MaxWidth);
							h_q <= clampd(ch_q, MaxHeight);
							x_q <= '0; y_q <= '0;
							pix_q <= pixel_in;
							st_q <= S_LRD;
						end else if (!full) begin
							pix_q <= pixel_in;
							st_q <= S_LRD;
						end
					end else if (!full) begin
						opix_q <= '0; olast_q <= 1'b0; oerr_q <= 1'b1;
						out_valid <= 1'b1;
					end else begin
						k_q <= '0; acc_q <= '0; st_q <= S_ERD;
					end
				end
				S_LRD: begin
					rs_q <= x_q == '0 ? SW'(pix_q) : rs_q + SW'(pix_q);
					st_q <= S_LWR;
				end
				S_LWR: begin
					lc_q <= lc_q + 17'd1;
					if (div_start) begin
						x_q <= '0; y_q <= '0;
						st_q <= S_DIV;
					end else begin
						if (9'(x_q) + 9'd1 == w_q) begin
							x_q <= '0; y_q <= y_q + YW'(1);
						end else x_q <= x_q + XW'(1);
						st_q <= S_IDLE;
					end
				end
				S_DIV: if (div_done) begin
					win_q <= quo; st_q <= S_IDLE;
				end
				S_ERD: begin
					// k: address issued at k, data at k+1
					cz_q <= cr == 9'd0 || cc == 9'd0;
					if (k_q != '0) begin
						case (k_q)
							3'd1, 3'd2: acc_q <= cz_q ? acc_q : acc_q + (SW+2)'(rd_q);
							default: acc_q <= cz_q ? acc_q : acc_q - (SW+2)'(rd_q);
						endcase
					end
					if (k_q == 3'd0) begin
						p_q <= prd_q;
						cnt_q <= 17'(he - hb) * 17'(we - wb);
					end
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) st_q <= S_EMUL;
				end
				S_EMUL: begin
					bord_q <= (34'(acc_q[SW-1:0]) * 34'(10'd256 - t)) >> 8;
					pc_q <= 34'(p_q) * 34'(cnt_q);
					st_q <= S_ECMP;
				end
				S_ECMP: begin
					opix_q <= pc_q < bord_q ? 8'd0 : PIX_WHITE;
					olast_q <= ec_q + 17'd1 == total;
					oerr_q <= 1'b0;
					out_valid <= 1'b1;
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (ec_q + 17'd1 == total) begin
						ec_q <= '0; lc_q <= '0; rs_q <= '0;
						x_q <= '0; y_q <= '0;
					end else begin
						ec_q <= ec_q + 17'd1;
						if (9'(x_q) + 9'd1 == w_q) begin
							x_q <= '0; y_q <= y_q + YW'(1);
						end else x_q <= x_q + XW'(1);
					end
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
